[sv/cds_pkg.sv]
package cds_pkg;

   // Field widths of the request and response beats
   localparam int DAY_W        = 5;
   localparam int MONTH_W      = 4;
   localparam int YEAR_W       = 14;
   localparam int COUNT_W      = 16;
   localparam int ORDER_W      = 2;
   localparam int DIST_W       = 22;
   localparam int OPCODE_W     = 2;
   localparam int REQ_DATA_W   = 40;
   localparam int RSP_DATA_W   = 56;

   // Defaults for the top-level parameters
   localparam int COUNT_BITS_DEF = 16;
   localparam int YEAR_MAX_DEF   = 9999;

   // Divisibility by 25 on a year: multiply by the inverse of 25 modulo 2^YEAR_W
   // and compare with the largest quotient that fits
   localparam logic [YEAR_W-1:0] INV25     = YEAR_W'(7209);
   localparam logic [YEAR_W-1:0] DIV25_TOP = YEAR_W'(((1 << YEAR_W) - 1) / 25);

   typedef enum logic [OPCODE_W-1:0] {
      OP_LOAD = 2'd0,
      OP_ADD  = 2'd1,
      OP_SUB  = 2'd2,
      OP_DIST = 2'd3
   } opcode_type;

   typedef enum logic [ORDER_W-1:0] {
      ORD_EQUAL   = 2'd0,
      ORD_LATER   = 2'd1,
      ORD_EARLIER = 2'd2
   } order_type;

   // Controller to datapath
   typedef struct packed {
      logic start;
      logic step;
      logic finish;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic done;
   } status_type;

   // Gregorian leap rule: by 4, but centuries only when also by 400
   function automatic logic is_leap(input logic [YEAR_W-1:0] y);
      logic [YEAR_W-1:0] r;
      logic              div4;
      logic              div16;
      logic              div25;
      r     = y * INV25;
      div4  = (y[1:0] == 2'd0);
      div16 = (y[3:0] == 4'd0);
      div25 = (r <= DIV25_TOP);
      return div4 && (!div25 || div16);
   endfunction

   // Length of a month; zero for a month number that does not exist
   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [DAY_W-1:0] len;
      case (m)
         4'd2:                                   len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:                len = 5'd30;
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         default:                                len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic logic date_ok(input logic [DAY_W-1:0]   d,
                                    input logic [MONTH_W-1:0] m,
                                    input logic [YEAR_W-1:0]  y,
                                    input logic [YEAR_W-1:0]  y_max);
      logic yr_ok;
      logic mo_ok;
      yr_ok = (y != '0) && (y <= y_max);
      mo_ok = (m != '0) && (m <= 4'd12);
      return yr_ok && mo_ok && (d != '0) && (d <= month_days(m, is_leap(y)));
   endfunction

endpackage

[sv/cds_ctrl.sv]
module cds_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output cds_pkg::cmd_type     cmd,
   input  cds_pkg::status_type  status
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      slot_free;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // Sequence one item: take it, step until done, then hand over the result
   always_comb begin
      state_in   = state_ff;
      cmd.start  = 1'b0;
      cmd.step   = 1'b0;
      cmd.finish = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!status.done) begin
               cmd.step = 1'b1;
            end else if (slot_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Load the output slot on finish, drop it once taken
   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[sv/cds_datapath.sv]
module cds_datapath #(
   parameter int COUNT_BITS = cds_pkg::COUNT_BITS_DEF,
   parameter int YEAR_MAX   = cds_pkg::YEAR_MAX_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  cds_pkg::cmd_type                cmd,
   output cds_pkg::status_type             status,
   input  logic [cds_pkg::OPCODE_W-1:0]    in_opcode,
   input  logic [cds_pkg::DAY_W-1:0]       in_day,
   input  logic [cds_pkg::MONTH_W-1:0]     in_month,
   input  logic [cds_pkg::YEAR_W-1:0]      in_year,
   input  logic [cds_pkg::COUNT_W-1:0]     in_count,
   output logic [cds_pkg::DAY_W-1:0]       out_day,
   output logic [cds_pkg::MONTH_W-1:0]     out_month,
   output logic [cds_pkg::YEAR_W-1:0]      out_year,
   output logic [cds_pkg::ORDER_W-1:0]     out_order,
   output logic [cds_pkg::DIST_W-1:0]      out_distance,
   output logic                            out_at_limit,
   output logic                            out_bad_date
);

   localparam int CNT_W = (COUNT_BITS < cds_pkg::COUNT_W) ? COUNT_BITS : cds_pkg::COUNT_W;
   localparam logic [cds_pkg::YEAR_W-1:0] YEAR_TOP = cds_pkg::YEAR_W'(YEAR_MAX);
   localparam int KEY_W = cds_pkg::YEAR_W + cds_pkg::MONTH_W + cds_pkg::DAY_W;

   // Stored date
   logic [cds_pkg::DAY_W-1:0]   cur_d_ff, cur_d_in;
   logic [cds_pkg::MONTH_W-1:0] cur_m_ff, cur_m_in;
   logic [cds_pkg::YEAR_W-1:0]  cur_y_ff, cur_y_in;

   // Walking date, given date and item context
   logic [cds_pkg::DAY_W-1:0]   wrk_d_ff, wrk_d_in;
   logic [cds_pkg::MONTH_W-1:0] wrk_m_ff, wrk_m_in;
   logic [cds_pkg::YEAR_W-1:0]  wrk_y_ff, wrk_y_in;
   logic [cds_pkg::DAY_W-1:0]   gvn_d_ff;
   logic [cds_pkg::MONTH_W-1:0] gvn_m_ff;
   logic [cds_pkg::YEAR_W-1:0]  gvn_y_ff;
   cds_pkg::opcode_type         op_ff;
   cds_pkg::order_type          ord_ff;
   logic [CNT_W-1:0]            cnt_ff;
   logic [cds_pkg::DIST_W-1:0]  dist_ff;
   logic                        bad_ff;

   // Result slot
   logic [cds_pkg::DAY_W-1:0]   out_d_ff;
   logic [cds_pkg::MONTH_W-1:0] out_m_ff;
   logic [cds_pkg::YEAR_W-1:0]  out_y_ff;
   logic [cds_pkg::ORDER_W-1:0] out_ord_ff;
   logic [cds_pkg::DIST_W-1:0]  out_dist_ff;
   logic                        out_lim_ff;
   logic                        out_bad_ff;

   logic [KEY_W-1:0]            cur_key;
   logic [KEY_W-1:0]            in_key;
   logic [KEY_W-1:0]            wrk_key;
   logic [KEY_W-1:0]            gvn_key;
   logic                        wrk_leap;
   logic [cds_pkg::DAY_W-1:0]   wrk_len;
   logic [cds_pkg::DAY_W-1:0]   prev_len;
   logic [cds_pkg::DAY_W-1:0]   nxt_d, prv_d;
   logic [cds_pkg::MONTH_W-1:0] nxt_m, prv_m;
   logic [cds_pkg::YEAR_W-1:0]  nxt_y, prv_y;
   logic                        at_top;
   logic                        at_first;
   logic                        go_back;
   logic                        is_step_op;

   assign cur_key  = {cur_y_ff, cur_m_ff, cur_d_ff};
   assign in_key   = {in_year, in_month, in_day};
   assign wrk_key  = {wrk_y_ff, wrk_m_ff, wrk_d_ff};
   assign gvn_key  = {gvn_y_ff, gvn_m_ff, gvn_d_ff};
   assign at_top   = (wrk_key == {YEAR_TOP, 4'd12, 5'd31});
   assign at_first = (wrk_key == {cds_pkg::YEAR_W'(1), 4'd1, 5'd1});
   assign is_step_op = (op_ff == cds_pkg::OP_ADD) || (op_ff == cds_pkg::OP_SUB);

   // Next and previous calendar day of the walking date
   assign wrk_leap = cds_pkg::is_leap(wrk_y_ff);
   assign wrk_len  = cds_pkg::month_days(wrk_m_ff, wrk_leap);
   assign prev_len = cds_pkg::month_days(wrk_m_ff - 4'd1, wrk_leap);

   always_comb begin
      nxt_d = wrk_d_ff + 5'd1;
      nxt_m = wrk_m_ff;
      nxt_y = wrk_y_ff;
      if (wrk_d_ff >= wrk_len) begin
         nxt_d = 5'd1;
         if (wrk_m_ff == 4'd12) begin
            nxt_m = 4'd1;
            nxt_y = wrk_y_ff + 14'd1;
         end else begin
            nxt_m = wrk_m_ff + 4'd1;
         end
      end
   end

   always_comb begin
      prv_d = wrk_d_ff - 5'd1;
      prv_m = wrk_m_ff;
      prv_y = wrk_y_ff;
      if (wrk_d_ff == 5'd1) begin
         if (wrk_m_ff == 4'd1) begin
            prv_d = 5'd31;
            prv_m = 4'd12;
            prv_y = wrk_y_ff - 14'd1;
         end else begin
            prv_d = prev_len;
            prv_m = wrk_m_ff - 4'd1;
         end
      end
   end

   // Item is complete when no step remains or a bound blocks the next one
   always_comb begin
      case (op_ff)
         cds_pkg::OP_LOAD: status.done = 1'b1;
         cds_pkg::OP_ADD:  status.done = (cnt_ff == '0) || at_top;
         cds_pkg::OP_SUB:  status.done = (cnt_ff == '0) || at_first;
         cds_pkg::OP_DIST: status.done = bad_ff || (wrk_key == gvn_key);
         default:          status.done = 1'b1;
      endcase
   end

   assign go_back = (op_ff == cds_pkg::OP_SUB) ||
                    ((op_ff == cds_pkg::OP_DIST) && (ord_ff == cds_pkg::ORD_LATER));

   always_comb begin
      wrk_d_in = wrk_d_ff;
      wrk_m_in = wrk_m_ff;
      wrk_y_in = wrk_y_ff;
      if (cmd.start) begin
         wrk_d_in = cur_d_ff;
         wrk_m_in = cur_m_ff;
         wrk_y_in = cur_y_ff;
      end else if (cmd.step) begin
         if (go_back) begin
            wrk_d_in = prv_d;
            wrk_m_in = prv_m;
            wrk_y_in = prv_y;
         end else begin
            wrk_d_in = nxt_d;
            wrk_m_in = nxt_m;
            wrk_y_in = nxt_y;
         end
      end
   end

   // Commit the stored date on finish
   always_comb begin
      cur_d_in = cur_d_ff;
      cur_m_in = cur_m_ff;
      cur_y_in = cur_y_ff;
      if (cmd.finish) begin
         if ((op_ff == cds_pkg::OP_LOAD) && !bad_ff) begin
            cur_d_in = gvn_d_ff;
            cur_m_in = gvn_m_ff;
            cur_y_in = gvn_y_ff;
         end else if (is_step_op) begin
            cur_d_in = wrk_d_ff;
            cur_m_in = wrk_m_ff;
            cur_y_in = wrk_y_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_d_ff <= 5'd1;
         cur_m_ff <= 4'd1;
         cur_y_ff <= 14'd1;
      end else begin
         cur_d_ff <= cur_d_in;
         cur_m_ff <= cur_m_in;
         cur_y_ff <= cur_y_in;
      end
   end

   // Capture the item, then walk
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= cds_pkg::OP_LOAD;
      end else if (cmd.start) begin
         op_ff <= cds_pkg::opcode_type'(in_opcode);
      end
   end

   always_ff @(posedge clock) begin
      wrk_d_ff <= wrk_d_in;
      wrk_m_ff <= wrk_m_in;
      wrk_y_ff <= wrk_y_in;
      if (cmd.start) begin
         gvn_d_ff <= in_day;
         gvn_m_ff <= in_month;
         gvn_y_ff <= in_year;
         cnt_ff   <= in_count[CNT_W-1:0];
         dist_ff  <= '0;
         bad_ff   <= !cds_pkg::date_ok(in_day, in_month, in_year, YEAR_TOP);
         if (cur_key > in_key) begin
            ord_ff <= cds_pkg::ORD_LATER;
         end else if (cur_key < in_key) begin
            ord_ff <= cds_pkg::ORD_EARLIER;
         end else begin
            ord_ff <= cds_pkg::ORD_EQUAL;
         end
      end else if (cmd.step) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (dist_ff != '1) begin
            dist_ff <= dist_ff + 1'b1;
         end
      end
   end

   // Fill the result slot
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_d_ff    <= cur_d_in;
         out_m_ff    <= cur_m_in;
         out_y_ff    <= cur_y_in;
         out_lim_ff  <= is_step_op && (cnt_ff != '0);
         out_bad_ff  <= !is_step_op && bad_ff;
         if ((op_ff == cds_pkg::OP_DIST) && !bad_ff) begin
            out_ord_ff  <= ord_ff;
            out_dist_ff <= dist_ff;
         end else begin
            out_ord_ff  <= cds_pkg::ORD_EQUAL;
            out_dist_ff <= '0;
         end
      end
   end

   assign out_day      = out_d_ff;
   assign out_month    = out_m_ff;
   assign out_year     = out_y_ff;
   assign out_order    = out_ord_ff;
   assign out_distance = out_dist_ff;
   assign out_at_limit = out_lim_ff;
   assign out_bad_date = out_bad_ff;

endmodule

[sv/calendar_date_stepper.sv]
// Channel  Direction  Handshake               Payload
// req      in         req_tvalid/req_tready   tuser: opcode; tdata: date, day count
// rsp      out        rsp_tvalid/rsp_tready   tdata: date, order, distance, flags
//
// Load walks no days; add and subtract walk n days, where n is the count or the days
// left to the bound; distance walks the day gap.
// The one day-step unit advances or retreats the walking date by one day per cycle.
// Synchronous reset sets the stored date to 0001-01-01 and empties the result slot.
// One item is in work at a time; a new item is taken while a result waits, but it
// does not finish until the waiting result has been taken.
module calendar_date_stepper #(
   parameter int COUNT_BITS = cds_pkg::COUNT_BITS_DEF,
   parameter int YEAR_MAX   = cds_pkg::YEAR_MAX_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [4:0] in_day, [8:5] in_month, [22:9] in_year, [38:23] day_count, [39] zero
   input  logic [cds_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [1:0] opcode
   input  logic [cds_pkg::OPCODE_W-1:0]     req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [4:0] out_day, [8:5] out_month, [22:9] out_year, [24:23] order,
   // [46:25] distance, [47] at_limit, [48] bad_date, [55:49] zero
   output logic [cds_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   cds_pkg::cmd_type             cmd;
   cds_pkg::status_type          status;
   logic [cds_pkg::DAY_W-1:0]    out_day;
   logic [cds_pkg::MONTH_W-1:0]  out_month;
   logic [cds_pkg::YEAR_W-1:0]   out_year;
   logic [cds_pkg::ORDER_W-1:0]  out_order;
   logic [cds_pkg::DIST_W-1:0]   out_distance;
   logic                         out_at_limit;
   logic                         out_bad_date;

   cds_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   cds_datapath #(
      .COUNT_BITS (COUNT_BITS),
      .YEAR_MAX   (YEAR_MAX)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .in_opcode    (req_tuser),
      .in_day       (req_tdata[4:0]),
      .in_month     (req_tdata[8:5]),
      .in_year      (req_tdata[22:9]),
      .in_count     (req_tdata[38:23]),
      .out_day      (out_day),
      .out_month    (out_month),
      .out_year     (out_year),
      .out_order    (out_order),
      .out_distance (out_distance),
      .out_at_limit (out_at_limit),
      .out_bad_date (out_bad_date)
   );

   // Pack the response beat
   assign rsp_tdata = {7'd0, out_bad_date, out_at_limit, out_distance, out_order,
                       out_year, out_month, out_day};

endmodule

[sv/cds_checker.sv]
module cds_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [cds_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   // Hold a stalled response beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   // Take no second request right after one is taken
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while item in work");

   // Report a stored date that exists in shape
   a_date_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[8:5] != 4'd0) && (rsp_tdata[8:5] <= 4'd12) &&
                     (rsp_tdata[4:0] != 5'd0) && (rsp_tdata[22:9] != 14'd0))
      else $error("response date out of range");

   // Order and distance agree, and the two flags never meet
   a_order_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[24:23] != 2'd3) &&
                     ((rsp_tdata[24:23] == 2'd0) == (rsp_tdata[46:25] == 22'd0)) &&
                     !(rsp_tdata[47] && rsp_tdata[48]))
      else $error("inconsistent order, distance or flags");

endmodule

bind calendar_date_stepper cds_checker u_cds_checker (.*);
